### rtl/dto_pkg.sv
// Shared types and constants for the disturbance torque observer.
// No dependencies; imported by dto_alpha, dto_lane and the top level.
package dto_pkg;

  localparam int AXES      = 3;
  localparam int RUN_W     = 16;
  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  // Quotient bits of dH/dt before the overflow cut (2^20 * 1e9 < 2^50)
  localparam int DIV_STEPS = 50;
  // Quotient bits of alpha in Q0.31
  localparam int ALPHA_STEPS = 31;

  localparam logic [29:0] NS_PER_S = 30'd1000000000;

  // Field widths that follow from the fixed formats
  localparam int CFG_W = 40;

  typedef enum logic [2:0] {
    CFG_TAU      = 3'd0,
    CFG_MAX_STEP = 3'd1,
    CFG_LATCH    = 3'd2,
    CFG_CLEAR    = 3'd3,
    CFG_PERSIST  = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNCONF  = 3'd1,
    ST_FIRST   = 3'd2,
    ST_ORDER   = 3'd3,
    ST_LONG    = 3'd4,
    ST_OVF     = 3'd5
  } status_t;

  typedef struct packed {
    logic start;   // latch operands, begin raw torque
    logic filt;    // run the low-pass update with the given alpha
    logic commit;  // take the new estimate as filter state
  } lane_cmd_t;

  typedef struct packed {
    logic raw_rdy;
    logic raw_ovf;
    logic filt_rdy;
    logic filt_ovf;
  } lane_stat_t;

endpackage

### rtl/dto_alpha.sv
// Filter gain unit: alpha = floor(dt * 2^31 / (tau + dt)), one bit a cycle.
// Depends on dto_pkg.
module dto_alpha import dto_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dt,
  input  logic [39:0] tau,
  output logic        done,
  output logic [30:0] alpha
);

  typedef enum logic [1:0] {A_IDLE, A_RUN, A_DONE} a_state_t;

  a_state_t    state_r;
  logic [40:0] denom_r;
  logic [40:0] rem_r;
  logic [30:0] quo_r;
  logic [4:0]  cnt_r;
  logic [41:0] trial;
  logic        take;

  assign trial = {rem_r, 1'b0};
  assign take  = (trial >= {1'b0, denom_r});
  assign done  = (state_r == A_DONE);
  assign alpha = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      denom_r <= '0;
      rem_r   <= '0;
      quo_r   <= '0;
      cnt_r   <= '0;
    end else if (start) begin
      denom_r <= {1'b0, tau} + {9'd0, dt};
      rem_r   <= {9'd0, dt};
      quo_r   <= '0;
      cnt_r   <= 5'(ALPHA_STEPS - 1);
      state_r <= A_RUN;
    end else begin
      case (state_r)
        A_RUN: begin
          rem_r <= take ? 41'(trial - {1'b0, denom_r}) : trial[40:0];
          quo_r <= {quo_r[29:0], take};
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == '0) state_r <= A_DONE;
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/dto_lane.sv
// One axis of the observer: dH/dt by long division, w x H term, raw torque,
// low-pass update and the squared estimate. Depends on dto_pkg.
module dto_lane import dto_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  lane_cmd_t          cmd,
  input  logic signed [32:0] delta,
  input  logic [31:0]        dt,
  input  logic signed [31:0] w_a,
  input  logic signed [31:0] h_b,
  input  logic signed [31:0] w_b,
  input  logic signed [31:0] h_a,
  input  logic signed [31:0] m,
  input  logic [30:0]        alpha,
  output lane_stat_t         stat,
  output logic signed [31:0] raw,
  output logic signed [31:0] next,
  output logic [63:0]        sq
);

  typedef enum logic [3:0] {
    L_IDLE, L_MUL, L_PREP, L_DIV, L_RAW, L_RDY, L_FMUL, L_FADD, L_FSQ, L_FDONE
  } l_state_t;

  l_state_t           state_r;
  logic               neg_r;
  logic [32:0]        absd_r;
  logic [31:0]        dt_r;
  logic signed [31:0] wa_r, hb_r, wb_r, ha_r, m_r;
  logic [62:0]        num_r;
  logic signed [63:0] p1_r, p2_r;
  logic               big_r;
  logic [31:0]        rem_r;
  logic [49:0]        nb_r;
  logic [49:0]        quo_r;
  logic [5:0]         cnt_r;
  logic signed [46:0] cr_r;
  logic signed [31:0] raw_r;
  logic               rovf_r;
  logic signed [64:0] prod_r;
  logic signed [31:0] next_r;
  logic               fovf_r;
  logic [63:0]        sq_r;
  logic signed [31:0] est_r;

  logic [32:0]        abs_in;
  logic [68:0]        numer;
  logic [32:0]        trial;
  logic               take;
  logic signed [64:0] crs;
  logic signed [51:0] qs, val;
  logic signed [32:0] diff;
  logic signed [64:0] rnd;
  logic signed [34:0] nx;
  logic signed [63:0] sqs;

  assign abs_in = delta[32] ? 33'(-delta) : delta;
  assign numer  = {num_r, 6'b0};
  assign trial  = {rem_r, nb_r[49]};
  assign take   = (trial >= {1'b0, dt_r});
  assign crs    = 65'(p1_r) - 65'(p2_r) + 65'sd131072;
  assign qs     = $signed({2'b00, quo_r});
  assign val    = (neg_r ? -qs : qs) + 52'(cr_r) - 52'(m_r);
  assign diff   = 33'(raw_r) - 33'(est_r);
  assign rnd    = prod_r + 65'sd1073741824;
  assign nx     = 35'(est_r) + 35'($signed(rnd[64:31]));
  assign sqs    = next_r * next_r;

  assign stat.raw_rdy  = (state_r == L_RDY);
  assign stat.raw_ovf  = rovf_r;
  assign stat.filt_rdy = (state_r == L_FDONE);
  assign stat.filt_ovf = fovf_r;
  assign raw  = raw_r;
  assign next = next_r;
  assign sq   = sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      est_r   <= '0;
      rovf_r  <= 1'b0;
      fovf_r  <= 1'b0;
    end else begin
      if (cmd.commit) est_r <= next_r;
      if (cmd.start) begin
        neg_r   <= delta[32];
        absd_r  <= abs_in;
        dt_r    <= dt;
        wa_r    <= w_a;
        hb_r    <= h_b;
        wb_r    <= w_b;
        ha_r    <= h_a;
        m_r     <= m;
        rovf_r  <= 1'b0;
        fovf_r  <= 1'b0;
        state_r <= L_MUL;
      end else begin
        case (state_r)
          L_MUL: begin
            num_r   <= 63'(absd_r * NS_PER_S);
            p1_r    <= wa_r * hb_r;
            p2_r    <= wb_r * ha_r;
            big_r   <= ({13'd0, absd_r, 6'b0} >= {dt_r, 20'd0});
            state_r <= L_PREP;
          end
          L_PREP: begin
            rem_r <= {13'd0, numer[68:50]};
            nb_r  <= numer[49:0];
            quo_r <= '0;
            cnt_r <= 6'(DIV_STEPS - 1);
            cr_r  <= crs[64:18];
            if (big_r) begin
              rovf_r  <= 1'b1;
              state_r <= L_RDY;
            end else begin
              state_r <= L_DIV;
            end
          end
          L_DIV: begin
            rem_r <= take ? 32'(trial - {1'b0, dt_r}) : trial[31:0];
            nb_r  <= {nb_r[48:0], 1'b0};
            quo_r <= {quo_r[48:0], take};
            cnt_r <= cnt_r - 6'd1;
            if (cnt_r == '0) state_r <= L_RAW;
          end
          L_RAW: begin
            raw_r   <= val[31:0];
            rovf_r  <= (val[51:31] != {21{val[31]}});
            state_r <= L_RDY;
          end
          L_RDY: begin
            if (cmd.filt) state_r <= L_FMUL;
          end
          L_FMUL: begin
            prod_r  <= 65'(diff) * 65'($signed({1'b0, alpha}));
            state_r <= L_FADD;
          end
          L_FADD: begin
            next_r  <= nx[31:0];
            fovf_r  <= (nx[34:31] != {4{nx[31]}});
            state_r <= L_FSQ;
          end
          L_FSQ: begin
            sq_r    <= sqs;
            state_r <= L_FDONE;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

### rtl/disturbance_torque_observer.sv
// Top level of the disturbance torque observer: config registers, anchor
// sample, three dto_lane axes, dto_alpha gain unit and the anomaly latch.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+----------------------------
//  input   | in_momentum_*, in_rate_*,       | in_valid / in_stall
//          | in_model_torque_*, in_time_tag  |
//  result  | out_estimate_*, out_raw_*, ...  | out_valid / out_stall
//  config  | cfg_index, cfg_wdata            | cfg_wr_en, no wait
//
// In an item that runs the full observer, the 50-step quotient loop of dH/dt
// in each lane is the longest part; the alpha divider (31 steps) runs beside
// it. Items refused in the check go from S_CHK straight to S_EMIT.
// One item is worked at a time; the next is taken while the last result
// still waits in the output register. Reset is synchronous, active low, and
// restores the config defaults and clears the observer state.
module disturbance_torque_observer import dto_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_momentum_x,
  input  logic signed [31:0] in_momentum_y,
  input  logic signed [31:0] in_momentum_z,
  input  logic signed [31:0] in_rate_x,
  input  logic signed [31:0] in_rate_y,
  input  logic signed [31:0] in_rate_z,
  input  logic signed [31:0] in_model_torque_x,
  input  logic signed [31:0] in_model_torque_y,
  input  logic signed [31:0] in_model_torque_z,
  input  logic signed [63:0] in_time_tag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_estimate_x,
  output logic signed [31:0] out_estimate_y,
  output logic signed [31:0] out_estimate_z,
  output logic signed [31:0] out_raw_x,
  output logic signed [31:0] out_raw_y,
  output logic signed [31:0] out_raw_z,
  output logic [31:0]        out_step_ns,
  output logic               out_anomaly,
  output logic               out_valid_res,
  output logic [2:0]         out_status,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHK, S_RUN, S_FILT, S_NORM, S_LATCH, S_EMIT
  } state_t;

  state_t state_r;

  // configuration
  logic [39:0] tau_r;
  logic [31:0] max_step_r;
  logic [30:0] latch_thr_r;
  logic [30:0] clear_thr_r;
  logic [15:0] persist_r;

  // captured item
  logic signed [31:0] h_r [AXES];
  logic signed [31:0] w_r [AXES];
  logic signed [31:0] m_r [AXES];
  logic signed [63:0] t_r;

  // observer state
  logic               have_anchor_r;
  logic signed [31:0] anchor_h_r [AXES];
  logic signed [63:0] anchor_t_r;
  logic               latch_r;
  logic [RUN_W-1:0]   above_r, below_r;

  // norm test
  logic [63:0] nsq_r, lsq_r, csq_r;

  // pending result
  logic signed [31:0] res_est_r [AXES];
  logic signed [31:0] res_raw_r [AXES];
  logic [31:0]        res_dt_r;
  logic               res_anom_r;
  logic               res_vres_r;
  status_t            res_status_r;

  // output register
  logic               out_valid_r;
  logic signed [31:0] out_est_r [AXES];
  logic signed [31:0] out_raw_r [AXES];
  logic [31:0]        out_dt_r;
  logic               out_anom_r;
  logic               out_vres_r;
  status_t            out_status_r;

  lane_cmd_t          cmd;
  lane_stat_t         lst [AXES];
  logic signed [32:0] delta [AXES];
  logic signed [31:0] lraw [AXES];
  logic signed [31:0] lnext [AXES];
  logic [63:0]        lsq [AXES];
  logic               a_done;
  logic [30:0]        alpha;

  logic               cfg_bad;
  logic [63:0]        dt64;
  logic               all_raw, any_raw_ovf, all_filt, any_filt_ovf;
  logic               out_free;
  logic               emit_go;
  logic [RUN_W-1:0]   run_max;
  logic [RUN_W-1:0]   above_nxt, below_nxt;

  assign cfg_bad = (tau_r == '0) || (max_step_r == '0) || (latch_thr_r == '0) ||
                   (clear_thr_r == '0) || (persist_r == '0) ||
                   (clear_thr_r > latch_thr_r);
  assign dt64     = t_r - anchor_t_r;
  assign out_free = !out_valid_r || !out_stall;
  assign emit_go  = (state_r == S_EMIT) && out_free;

  assign all_raw      = lst[0].raw_rdy && lst[1].raw_rdy && lst[2].raw_rdy;
  assign any_raw_ovf  = lst[0].raw_ovf || lst[1].raw_ovf || lst[2].raw_ovf;
  assign all_filt     = lst[0].filt_rdy && lst[1].filt_rdy && lst[2].filt_rdy;
  assign any_filt_ovf = lst[0].filt_ovf || lst[1].filt_ovf || lst[2].filt_ovf;

  // Saturate runs at persist_count or at the counter maximum.
  assign run_max   = (32'(persist_r) < 32'(RUN_MAX)) ? RUN_W'(persist_r) : RUN_MAX;
  assign above_nxt = (above_r < run_max) ? RUN_W'(above_r + 1'b1) : above_r;
  assign below_nxt = (below_r < run_max) ? RUN_W'(below_r + 1'b1) : below_r;

  always_comb begin
    cmd.start  = (state_r == S_CHK) && !cfg_bad && have_anchor_r &&
                 ($signed(t_r) > $signed(anchor_t_r)) &&
                 (dt64 <= {32'd0, max_step_r});
    cmd.filt   = (state_r == S_RUN) && all_raw && a_done && !any_raw_ovf;
    cmd.commit = (state_r == S_FILT) && all_filt && !any_filt_ovf;
  end

  dto_alpha u_alpha (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start),
    .dt    (dt64[31:0]),
    .tau   (tau_r),
    .done  (a_done),
    .alpha (alpha)
  );

  // Lane i forms (w x H)_i = w[i+1]*H[i+2] - w[i+2]*H[i+1].
  for (genvar i = 0; i < AXES; i++) begin : g_lane
    localparam int A1 = (i + 1) % AXES;
    localparam int A2 = (i + 2) % AXES;

    assign delta[i] = 33'(h_r[i]) - 33'(anchor_h_r[i]);

    dto_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .delta (delta[i]),
      .dt    (dt64[31:0]),
      .w_a   (w_r[A1]),
      .h_b   (h_r[A2]),
      .w_b   (w_r[A2]),
      .h_a   (h_r[A1]),
      .m     (m_r[i]),
      .alpha (alpha),
      .stat  (lst[i]),
      .raw   (lraw[i]),
      .next  (lnext[i]),
      .sq    (lsq[i])
    );
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_estimate_x = out_est_r[0];
  assign out_estimate_y = out_est_r[1];
  assign out_estimate_z = out_est_r[2];
  assign out_raw_x      = out_raw_r[0];
  assign out_raw_y      = out_raw_r[1];
  assign out_raw_z      = out_raw_r[2];
  assign out_step_ns    = out_dt_r;
  assign out_anomaly    = out_anom_r;
  assign out_valid_res  = out_vres_r;
  assign out_status     = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      tau_r         <= 40'd1000000000;
      max_step_r    <= 32'd1000000000;
      latch_thr_r   <= 31'd1073741824;
      clear_thr_r   <= 31'd536870912;
      persist_r     <= 16'd3;
      have_anchor_r <= 1'b0;
      anchor_t_r    <= '0;
      latch_r       <= 1'b0;
      above_r       <= '0;
      below_r       <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < AXES; i++) anchor_h_r[i] <= '0;
    end else begin
      // Config writes land whenever the enable is high.
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TAU:      tau_r       <= cfg_wdata[39:0];
          CFG_MAX_STEP: max_step_r  <= cfg_wdata[31:0];
          CFG_LATCH:    latch_thr_r <= cfg_wdata[30:0];
          CFG_CLEAR:    clear_thr_r <= cfg_wdata[30:0];
          CFG_PERSIST:  persist_r   <= cfg_wdata[15:0];
          default: ;
        endcase
      end

      // Load the output item from S_EMIT, or drop it once taken.
      if (emit_go) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            h_r[0] <= in_momentum_x;
            h_r[1] <= in_momentum_y;
            h_r[2] <= in_momentum_z;
            w_r[0] <= in_rate_x;
            w_r[1] <= in_rate_y;
            w_r[2] <= in_rate_z;
            m_r[0] <= in_model_torque_x;
            m_r[1] <= in_model_torque_y;
            m_r[2] <= in_model_torque_z;
            t_r    <= in_time_tag;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          // Refusals carry zeros in every field but status.
          for (int i = 0; i < AXES; i++) begin
            res_est_r[i] <= '0;
            res_raw_r[i] <= '0;
          end
          res_dt_r   <= cmd.start ? dt64[31:0] : 32'd0;
          res_anom_r <= 1'b0;
          res_vres_r <= 1'b0;
          if (cfg_bad) begin
            res_status_r <= ST_UNCONF;
            state_r      <= S_EMIT;
          end else begin
            // Every other path takes this sample as the new anchor.
            have_anchor_r <= 1'b1;
            anchor_t_r    <= t_r;
            for (int i = 0; i < AXES; i++) anchor_h_r[i] <= h_r[i];
            if (!have_anchor_r) begin
              res_status_r <= ST_FIRST;
              state_r      <= S_EMIT;
            end else if ($signed(t_r) <= $signed(anchor_t_r)) begin
              res_status_r <= ST_ORDER;
              state_r      <= S_EMIT;
            end else if (dt64 > {32'd0, max_step_r}) begin
              res_status_r <= ST_LONG;
              state_r      <= S_EMIT;
            end else begin
              state_r  <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (all_raw && a_done) begin
            if (any_raw_ovf) begin
              res_dt_r     <= '0;
              res_status_r <= ST_OVF;
              state_r      <= S_EMIT;
            end else begin
              state_r <= S_FILT;
            end
          end
        end
        S_FILT: begin
          if (all_filt) begin
            if (any_filt_ovf) begin
              // Hold estimate, runs and latch.
              res_dt_r     <= '0;
              res_status_r <= ST_OVF;
              state_r      <= S_EMIT;
            end else begin
              nsq_r   <= lsq[0] + lsq[1] + lsq[2];
              lsq_r   <= 64'(latch_thr_r * latch_thr_r);
              csq_r   <= 64'(clear_thr_r * clear_thr_r);
              state_r <= S_NORM;
            end
          end
        end
        S_NORM: begin
          // Above, below, or in the deadband where both runs restart.
          if (nsq_r > lsq_r) begin
            below_r <= '0;
            above_r <= above_nxt;
            if (32'(above_nxt) >= 32'(persist_r)) latch_r <= 1'b1;
          end else if (nsq_r < csq_r) begin
            above_r <= '0;
            below_r <= below_nxt;
            if (32'(below_nxt) >= 32'(persist_r)) latch_r <= 1'b0;
          end else begin
            above_r <= '0;
            below_r <= '0;
          end
          state_r <= S_LATCH;
        end
        S_LATCH: begin
          for (int i = 0; i < AXES; i++) begin
            res_est_r[i] <= lnext[i];
            res_raw_r[i] <= lraw[i];
          end
          res_anom_r   <= latch_r;
          res_vres_r   <= 1'b1;
          res_status_r <= ST_OK;
          state_r      <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            for (int i = 0; i < AXES; i++) begin
              out_est_r[i] <= res_est_r[i];
              out_raw_r[i] <= res_raw_r[i];
            end
            out_dt_r     <= res_dt_r;
            out_anom_r   <= res_anom_r;
            out_vres_r   <= res_vres_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A fresh estimate is only ever reported with an ok status.
  a_vres_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_vres_r) |-> (out_status_r == ST_OK))
    else $error("valid_res set on a refused item");

  // Refused items carry no step and no anomaly.
  a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_dt_r == '0 && !out_anom_r))
    else $error("refused item carries nonzero fields");

  // The lanes only start on an accepted, checked item.
  a_start_chk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> $past(state_r == S_IDLE && in_valid))
    else $error("lane start without a captured item");

  // The latch moves only in the norm step.
  a_latch_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_NORM) |=> $stable(latch_r))
    else $error("anomaly latch changed outside the norm step");

endmodule
